// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL folder.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");

// Check on rising clock edges outside reset.
`define ASSERT_RUN(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

`endif

// ----- hw/rtl/irpw_pkg.sv -----
// ---------------------------------------------------------------------------
// IR pulse-width decoder package
// Widths, register indexes and reset values of the decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package irpw_pkg;

   // bits in one command packet
   localparam int CMD_BITS   = 2;
   localparam int CNT_W      = (CMD_BITS > 1) ? $clog2(CMD_BITS) : 1;
   localparam int STORE_W    = (CMD_BITS < 2) ? 2 : CMD_BITS;

   localparam int INTV_W     = 16;
   localparam int ELAPSED_W  = 24;
   localparam int CMD_W      = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = {ELAPSED_W{1'b1}};
   localparam logic [ELAPSED_W-1:0] ELAPSED_RESET = 24'd30000;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_HEADER_MIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEADER_MAX = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ZERO_MIN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ZERO_MAX   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ONE_MIN    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ONE_MAX    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_HOLDOFF    = 3'd6;

   // register reset values
   localparam logic [INTV_W-1:0]    HEADER_MIN_RST = 16'd290;
   localparam logic [INTV_W-1:0]    HEADER_MAX_RST = 16'd315;
   localparam logic [INTV_W-1:0]    ZERO_MIN_RST   = 16'd110;
   localparam logic [INTV_W-1:0]    ZERO_MAX_RST   = 16'd135;
   localparam logic [INTV_W-1:0]    ONE_MIN_RST    = 16'd170;
   localparam logic [INTV_W-1:0]    ONE_MAX_RST    = 16'd195;
   localparam logic [ELAPSED_W-1:0] HOLDOFF_RST    = 24'd30000;

   typedef struct packed {
      logic header;
      logic zero;
      logic one;
   } window_type;

endpackage

// ----- hw/rtl/ir_pulse_width_command_decoder_core.sv -----
// ---------------------------------------------------------------------------
// IR pulse-width command decoder
// Classifies edge intervals against programmable windows and assembles
// short commands, LSB first, with a holdoff between emitted commands.
// ---------------------------------------------------------------------------
//  channel  direction  payload                     handshake
//  req_     in         pulse_interval [15:0]       req_tvalid / req_tready
//  rsp_     out        command [1:0], pad to 8     rsp_tvalid / rsp_tready
//  csr_     in         index [2:0], data [23:0]    csr_valid / csr_ready
//
//  One request per cycle while req_tready is high; the decode is a single pass
//  of window compares and a 24-bit saturating add; the result is registered.
//  A two-entry output buffer (output register plus skid) lets requests flow
//  while a result waits; req_tready drops only when the skid entry is full.
//  Synchronous reset restores register defaults, closes any packet and
//  loads the elapsed counter with its start value. csr_ready is always high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ir_pulse_width_command_decoder_core (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: [15:0] pulse_interval
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [irpw_pkg::INTV_W-1:0]       req_tdata,
   // rsp_tdata: [1:0] command, [7:2] zero
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [irpw_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [irpw_pkg::CSR_DATA_W-1:0]   csr_data
);

   // configuration
   logic [irpw_pkg::INTV_W-1:0]    header_min_ff, header_max_ff;
   logic [irpw_pkg::INTV_W-1:0]    zero_min_ff, zero_max_ff;
   logic [irpw_pkg::INTV_W-1:0]    one_min_ff, one_max_ff;
   logic [irpw_pkg::ELAPSED_W-1:0] holdoff_ff;

   // decoder state
   logic                           receiving_ff, receiving_in;
   logic [irpw_pkg::CNT_W-1:0]     bit_count_ff, bit_count_in;
   logic [irpw_pkg::STORE_W-1:0]   bit_store_ff, bit_store_in;
   logic [irpw_pkg::ELAPSED_W-1:0] elapsed_ff, elapsed_in;

   // output buffer
   logic                           main_valid_ff, skid_valid_ff;
   logic [irpw_pkg::CMD_W-1:0]     main_cmd_ff, skid_cmd_ff;

   logic                           accept, pop, emit;
   logic [irpw_pkg::ELAPSED_W:0]   elapsed_sum;
   logic [irpw_pkg::ELAPSED_W-1:0] elapsed_sat;
   logic [irpw_pkg::CMD_W-1:0]     cmd_in;
   logic                           bit_val;
   irpw_pkg::window_type           win;

   assign csr_ready  = 1'b1;
   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = main_valid_ff;
   assign pop        = main_valid_ff && rsp_tready;
   assign rsp_tdata  = {{(8 - irpw_pkg::CMD_W){1'b0}}, main_cmd_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         header_min_ff <= irpw_pkg::HEADER_MIN_RST;
         header_max_ff <= irpw_pkg::HEADER_MAX_RST;
         zero_min_ff   <= irpw_pkg::ZERO_MIN_RST;
         zero_max_ff   <= irpw_pkg::ZERO_MAX_RST;
         one_min_ff    <= irpw_pkg::ONE_MIN_RST;
         one_max_ff    <= irpw_pkg::ONE_MAX_RST;
         holdoff_ff    <= irpw_pkg::HOLDOFF_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            irpw_pkg::REG_HEADER_MIN: header_min_ff <= csr_data[irpw_pkg::INTV_W-1:0];
            irpw_pkg::REG_HEADER_MAX: header_max_ff <= csr_data[irpw_pkg::INTV_W-1:0];
            irpw_pkg::REG_ZERO_MIN:   zero_min_ff   <= csr_data[irpw_pkg::INTV_W-1:0];
            irpw_pkg::REG_ZERO_MAX:   zero_max_ff   <= csr_data[irpw_pkg::INTV_W-1:0];
            irpw_pkg::REG_ONE_MIN:    one_min_ff    <= csr_data[irpw_pkg::INTV_W-1:0];
            irpw_pkg::REG_ONE_MAX:    one_max_ff    <= csr_data[irpw_pkg::INTV_W-1:0];
            irpw_pkg::REG_HOLDOFF:    holdoff_ff    <= csr_data[irpw_pkg::ELAPSED_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      win.header = (req_tdata > header_min_ff) && (req_tdata < header_max_ff);
      win.zero   = (req_tdata > zero_min_ff) && (req_tdata < zero_max_ff);
      win.one    = (req_tdata > one_min_ff) && (req_tdata < one_max_ff);

      // saturate elapsed at all ones
      elapsed_sum = {1'b0, elapsed_ff}
                  + {{(irpw_pkg::ELAPSED_W + 1 - irpw_pkg::INTV_W){1'b0}}, req_tdata};
      elapsed_sat = elapsed_sum[irpw_pkg::ELAPSED_W] ? irpw_pkg::ELAPSED_MAX
                                                     : elapsed_sum[irpw_pkg::ELAPSED_W-1:0];

      bit_val      = !win.zero;
      receiving_in = receiving_ff;
      bit_count_in = bit_count_ff;
      bit_store_in = bit_store_ff;
      elapsed_in   = elapsed_sat;
      emit         = 1'b0;

      if (win.header) begin
         receiving_in = 1'b1;
         bit_count_in = '0;
      end else if (receiving_ff) begin
         if (win.zero || win.one) begin
            bit_store_in[bit_count_ff] = bit_val;
            bit_count_in = bit_count_ff + 1'b1;
            if (bit_count_ff == irpw_pkg::CNT_W'(irpw_pkg::CMD_BITS - 1)) begin
               receiving_in = 1'b0;
               if (elapsed_sat > holdoff_ff) begin
                  emit       = 1'b1;
                  elapsed_in = '0;
               end
            end
         end else begin
            receiving_in = 1'b0;
         end
      end

      cmd_in = bit_store_in[irpw_pkg::CMD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         receiving_ff <= 1'b0;
         bit_count_ff <= '0;
         elapsed_ff   <= irpw_pkg::ELAPSED_RESET;
      end else if (accept) begin
         receiving_ff <= receiving_in;
         bit_count_ff <= bit_count_in;
         elapsed_ff   <= elapsed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         bit_store_ff <= bit_store_in;
      end
   end

   // two-entry queue: pop takes the output register, push appends behind
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            main_valid_ff <= 1'b1;
            skid_valid_ff <= accept && emit;
         end else begin
            main_valid_ff <= accept && emit;
         end
      end else if (accept && emit) begin
         if (main_valid_ff) begin
            skid_valid_ff <= 1'b1;
         end else begin
            main_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (skid_valid_ff) begin
            main_cmd_ff <= skid_cmd_ff;
            skid_cmd_ff <= cmd_in;
         end else begin
            main_cmd_ff <= cmd_in;
         end
      end else if (accept && emit) begin
         if (main_valid_ff) begin
            skid_cmd_ff <= cmd_in;
         end else begin
            main_cmd_ff <= cmd_in;
         end
      end
   end

   `ASSERT_ALWAYS(a_skid_behind_main, clock, skid_valid_ff |-> main_valid_ff)
   `ASSERT_RUN(a_emit_clears_elapsed, clock, reset,
               (accept && emit) |=> (elapsed_ff == '0))
   `ASSERT_RUN(a_emit_closes_packet, clock, reset, (accept && emit) |=> !receiving_ff)
   `ASSERT_RUN(a_drain_empties, clock, reset,
               (pop && !skid_valid_ff && !(accept && emit)) |=> !main_valid_ff)
   `ASSERT_RUN(a_emit_is_visible, clock, reset, (accept && emit) |=> rsp_tvalid)

endmodule

// ----- sim/testbench.sv -----
// ---------------------------------------------------------------------------
// IR pulse-width command decoder testbench
// Streams edge intervals into the decoder under random burst/gap pacing and
// response backpressure, predicts every decoded command in a scoreboard and
// checks the responses in order across several window and holdoff settings.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import irpw_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 600000;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;

   typedef enum {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_SLOW} rx_pattern_e;

   // Tracks decoder state and the queue of commands still to come.
   class command_scoreboard;
      logic [INTV_W-1:0]    hdr_min, hdr_max, zero_min, zero_max, one_min, one_max;
      logic [ELAPSED_W-1:0] holdoff;
      bit                   receiving;
      int unsigned          bit_count;
      logic [7:0]           bit_store;
      logic [ELAPSED_W-1:0] elapsed;
      logic [CMD_W-1:0]     command_q[$];
      int unsigned          requests, commands, errors;

      function new();
         hdr_min   = HEADER_MIN_RST;
         hdr_max   = HEADER_MAX_RST;
         zero_min  = ZERO_MIN_RST;
         zero_max  = ZERO_MAX_RST;
         one_min   = ONE_MIN_RST;
         one_max   = ONE_MAX_RST;
         holdoff   = HOLDOFF_RST;
         receiving = 1'b0;
         bit_count = 0;
         bit_store = '0;
         elapsed   = ELAPSED_RESET;
         requests  = 0;
         commands  = 0;
         errors    = 0;
      endfunction

      function int pending();
         return command_q.size();
      endfunction

      function bit strictly_between(input logic [INTV_W-1:0] v, lo, hi);
         return (v > lo) && (v < hi);
      endfunction

      function void apply_reg(input logic [CSR_IDX_W-1:0] idx,
                              input logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_HEADER_MIN: hdr_min  = data[INTV_W-1:0];
            REG_HEADER_MAX: hdr_max  = data[INTV_W-1:0];
            REG_ZERO_MIN:   zero_min = data[INTV_W-1:0];
            REG_ZERO_MAX:   zero_max = data[INTV_W-1:0];
            REG_ONE_MIN:    one_min  = data[INTV_W-1:0];
            REG_ONE_MAX:    one_max  = data[INTV_W-1:0];
            REG_HOLDOFF:    holdoff  = data[ELAPSED_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_interval(input logic [INTV_W-1:0] t);
         logic [ELAPSED_W:0] sum;
         logic               bit_val;
         requests++;
         sum = {1'b0, elapsed} + t;
         elapsed = sum[ELAPSED_W] ? ELAPSED_MAX : sum[ELAPSED_W-1:0];
         // header test comes first, even in mid-packet
         if (strictly_between(t, hdr_min, hdr_max)) begin
            bit_count = 0;
            receiving = 1'b1;
            return;
         end
         if (!receiving)
            return;
         if (strictly_between(t, zero_min, zero_max))
            bit_val = 1'b0;
         else if (strictly_between(t, one_min, one_max))
            bit_val = 1'b1;
         else begin
            receiving = 1'b0;
            return;
         end
         if (bit_count < 8)
            bit_store[bit_count] = bit_val;
         bit_count++;
         if (bit_count >= CMD_BITS) begin
            receiving = 1'b0;
            if (elapsed > holdoff) begin
               command_q.push_back(bit_store[CMD_W-1:0]);
               elapsed = '0;
            end
         end
      endfunction

      function void check_command(input logic [7:0] tdata);
         logic [CMD_W-1:0] want;
         if (command_q.size() == 0) begin
            $display("%0t: unexpected command, expected none, actual %0d",
                     $time, tdata[CMD_W-1:0]);
            errors++;
            return;
         end
         want = command_q.pop_front();
         commands++;
         if (tdata[CMD_W-1:0] !== want) begin
            $display("%0t: command mismatch, expected %0d, actual %0d",
                     $time, want, tdata[CMD_W-1:0]);
            errors++;
         end
         if (tdata[7:CMD_W] !== '0) begin
            $display("%0t: pad bits mismatch, expected 0, actual 0x%0h",
                     $time, tdata[7:CMD_W]);
            errors++;
         end
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [INTV_W-1:0]     req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   command_scoreboard sb = new();

   rx_pattern_e rx_pattern = RX_ALWAYS;
   int unsigned rx_tick    = 0;
   int unsigned cycles     = 0;
   int          burst_left = 0;
   bit          paced      = 1'b1;
   int          settings   = 1;

   logic [INTV_W-1:0] opening [0:24] = '{
      300, 120, 180,            // clean packet past the holdoff
      300, 120, 120,            // complete but inside the holdoff
      180,                      // bit with no packet open
      300, 180, 300, 120, 180,  // header restarts an open packet
      300, 150, 120,            // out-of-window interval aborts
      0, 290, 315, 291, 111, 194,
      65535, 300, 134, 171
   };

   ir_pulse_width_command_decoder_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d commands outstanding", $time, sb.pending());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            sb.apply_reg(csr_index, csr_data);
         if (req_tvalid && req_tready)
            sb.note_interval(req_tdata);
         if (rsp_tvalid && rsp_tready)
            sb.check_command(rsp_tdata);
      end
   end

   always @(negedge clock) begin
      rx_tick <= rx_tick + 1;
      case (rx_pattern)
         RX_ALWAYS:   rsp_tready <= 1'b1;
         RX_RANDOM:   rsp_tready <= ($urandom_range(0, 2) != 0);
         RX_PERIODIC: rsp_tready <= ((rx_tick % 9) > 3);
         default:     rsp_tready <= ((rx_tick % 40) > 25);
      endcase
   end

   task automatic push_interval(input logic [INTV_W-1:0] v);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = paced ? $urandom_range(0, 5) : 0;
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Hold requests until every predicted command has come out.
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Upper data bits of the 16-bit registers carry junk that must be dropped.
   task automatic load_windows(input int hmin, hmax, zmin, zmax, omin, omax,
                               input int hold);
      settle();
      csr_write(REG_HEADER_MIN, {8'($urandom), 16'(hmin)});
      csr_write(REG_HEADER_MAX, {8'($urandom), 16'(hmax)});
      csr_write(REG_ZERO_MIN,   {8'($urandom), 16'(zmin)});
      csr_write(REG_ZERO_MAX,   {8'($urandom), 16'(zmax)});
      csr_write(REG_ONE_MIN,    {8'($urandom), 16'(omin)});
      csr_write(REG_ONE_MAX,    {8'($urandom), 16'(omax)});
      csr_write(REG_HOLDOFF,    24'(hold));
      settings++;
   endtask

   function automatic logic [INTV_W-1:0] pick_in_window(input int lo, hi);
      if (hi > lo + 1)
         return 16'($urandom_range(hi - 1, lo + 1));
      return 16'($urandom);
   endfunction

   function automatic logic [INTV_W-1:0] noise_interval();
      if ($urandom_range(0, 1))
         return 16'($urandom);
      return 16'($urandom_range(0, 400));
   endfunction

   // Mostly well-formed packets, with aborts, restarts and stray intervals.
   task automatic random_traffic(input int count);
      int sent;
      int pick;
      logic [INTV_W-1:0] v;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) < 7) begin
            push_interval(pick_in_window(sb.hdr_min, sb.hdr_max));
            sent++;
            for (int i = 0; i < CMD_BITS; i++) begin
               pick = $urandom_range(0, 19);
               if (pick == 0)
                  v = noise_interval();
               else if (pick == 1)
                  v = pick_in_window(sb.hdr_min, sb.hdr_max);
               else if (pick[0])
                  v = pick_in_window(sb.zero_min, sb.zero_max);
               else
                  v = pick_in_window(sb.one_min, sb.one_max);
               push_interval(v);
               sent++;
            end
         end else begin
            push_interval(noise_interval());
            sent++;
         end
      end
   endtask

   initial begin
      int h, z, o;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      rx_pattern = RX_RANDOM;
      foreach (opening[i]) push_interval(opening[i]);

      // reset windows, short holdoff so commands come often
      load_windows(290, 315, 110, 135, 170, 195, $urandom_range(0, 1500));
      random_traffic(200);
      settle();
      rx_pattern = RX_SLOW;
      random_traffic(200);

      // header overlaps zero, zero overlaps one
      rx_pattern = RX_PERIODIC;
      load_windows(100, 200, 150, 260, 140, 400, 0);
      random_traffic(300);

      // one-value windows at the field extremes, full rate on both sides
      rx_pattern = RX_ALWAYS;
      paced = 1'b0;
      load_windows(65533, 65535, 0, 2, 2, 4, 0);
      random_traffic(300);

      // every window wide open, so the header always wins
      paced = 1'b1;
      rx_pattern = RX_RANDOM;
      load_windows(0, 65535, 0, 65535, 0, 65535, 24'hFFFFFF);
      csr_write(REG_UNUSED, 24'($urandom));
      random_traffic(40);

      // drive elapsed into saturation, then drop the holdoff just below it
      load_windows(290, 315, 110, 135, 170, 195, 24'hFFFFFF);
      repeat (260) push_interval(16'hFFFF);
      push_interval(300);
      push_interval(120);
      push_interval(180);
      load_windows(290, 315, 110, 135, 170, 195, 24'hFFFFFE);
      push_interval(300);
      push_interval(180);
      push_interval(120);

      repeat (4) begin
         h = $urandom_range(0, 65000);
         z = $urandom_range(0, 65000);
         o = $urandom_range(0, 65000);
         load_windows(h, h + $urandom_range(0, 500), z, z + $urandom_range(0, 500),
                      o, o + $urandom_range(0, 500), $urandom_range(0, 3000));
         random_traffic(100);
      end

      load_windows(HEADER_MIN_RST, HEADER_MAX_RST, ZERO_MIN_RST, ZERO_MAX_RST,
                   ONE_MIN_RST, ONE_MAX_RST, HOLDOFF_RST);
      random_traffic(100);

      settle();
      repeat (10) @(posedge clock);
      $display("Decoded %0d commands from %0d pulse intervals over %0d register settings,",
               sb.commands, sb.requests, settings);
      $display("with overlapping windows, elapsed saturation, gaps and backpressure.");
      if (sb.errors == 0 && sb.pending() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/irpw_pkg.sv
hw/rtl/ir_pulse_width_command_decoder_core.sv
sim/testbench.sv
